@@ hdl/xalu_pkg.sv @@
// ----------------------------------------------------------------------------
// xalu_pkg
// Shared types, op codes, size codes and flag masks for the x86 integer ALU.
// ----------------------------------------------------------------------------
package xalu_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned HALF_W = 32;
    localparam int unsigned FLAG_W = 6;

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [FLAG_W-1:0] t_fmask;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_ADC  = 4'd2,
        OP_SBB  = 4'd3,
        OP_INC  = 4'd4,
        OP_DEC  = 4'd5,
        OP_NEG  = 4'd6,
        OP_XADD = 4'd7,
        OP_MUL  = 4'd8,
        OP_IMUL = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        SIZE_8  = 2'd0,
        SIZE_16 = 2'd1,
        SIZE_32 = 2'd2,
        SIZE_64 = 2'd3
    } t_size;

    localparam t_fmask FLAGS_NONE  = 6'h00;
    localparam t_fmask FLAGS_ALL   = 6'h3F;
    localparam t_fmask FLAGS_NO_CF = 6'h3E;
    localparam t_fmask FLAGS_CF_OF = 6'h21;

    typedef struct packed {
        logic of;
        logic sf;
        logic zf;
        logic af;
        logic pf;
        logic cf;
    } t_flags;

    function automatic t_word size_mask(t_size sz);
        t_word m;
        case (sz)
            SIZE_8:  m = 64'h0000_0000_0000_00FF;
            SIZE_16: m = 64'h0000_0000_0000_FFFF;
            SIZE_32: m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic t_word size_sign(t_size sz);
        t_word s;
        case (sz)
            SIZE_8:  s = 64'h0000_0000_0000_0080;
            SIZE_16: s = 64'h0000_0000_0000_8000;
            SIZE_32: s = 64'h0000_0000_8000_0000;
            default: s = 64'h8000_0000_0000_0000;
        endcase
        return s;
    endfunction

endpackage

@@ hdl/x86_integer_alu_with_flags_core.sv @@
// path: input register, partial products, combined product and output register, the same for every op
// throughput: one item per cycle while i_stall is low; the 64x64 multiply is
// split into four 32x32 partial products in stage 2 and combined in stage 3
// stages advance independently, so bubbles close up under output stall
// reset: synchronous active low, clears all stage valid bits
// ----------------------------------------------------------------------------
// x86_integer_alu_with_flags_core
// Pipelined x86 integer ALU: add/sub family, inc/dec/neg, xadd, mul, imul
// at 8/16/32/64 bits with CF, PF, AF, ZF, SF, OF and a flag write mask.
// ----------------------------------------------------------------------------
module x86_integer_alu_with_flags_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_op,
    input  logic [1:0]  i_size_code,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    input  logic        i_carry_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result,
    output logic [63:0] o_second_value,
    output logic        o_carry_flag,
    output logic        o_parity_flag,
    output logic        o_adjust_flag,
    output logic        o_zero_flag,
    output logic        o_sign_flag,
    output logic        o_overflow_flag,
    output logic [5:0]  o_flag_write_mask
);
    import xalu_pkg::*;

    // stage enables
    logic en1, en2, en3, en4;

    // stage 1: input register
    logic       r1_valid;
    logic [3:0] r1_op;
    t_size      r1_size;
    t_word      r1_a, r1_b;
    logic       r1_cin;

    // stage 2: partial products and add/sub results
    logic   r2_valid;
    logic   r2_is_mul, r2_is_imul;
    t_size  r2_size;
    t_word  r2_a, r2_b;
    t_word  r2_ll, r2_lh, r2_hl, r2_hh;
    t_word  r2_res, r2_second;
    t_flags r2_flags;
    t_fmask r2_fmask;

    // stage 3: combined product
    logic   r3_valid;
    logic   r3_is_mul, r3_is_imul;
    t_size  r3_size;
    t_word  r3_a, r3_b;
    t_word  r3_lo, r3_high;
    t_word  r3_res, r3_second;
    t_flags r3_flags;
    t_fmask r3_fmask;

    // stage 4: output register
    logic   r4_valid;
    t_word  r4_res, r4_second;
    t_flags r4_flags;
    t_fmask r4_fmask;

    t_word  n4_res, n4_second;
    t_flags n4_flags;
    t_fmask n4_fmask;

    assign en4     = !r4_valid || !i_stall;
    assign en3     = !r3_valid || en4;
    assign en2     = !r2_valid || en3;
    assign en1     = !r1_valid || en2;
    assign o_stall = !en1;

    // stage 2 logic
    t_word  s2_mask, s2_sign, s2_a, s2_b;
    t_word  s2_x, s2_y, s2_c, s2_r;
    logic   s2_sub;
    t_word  n2_res, n2_second;
    t_flags n2_flags;
    t_fmask n2_fmask;
    logic   n2_cf, n2_of;

    always_comb begin
        s2_mask = size_mask(r1_size);
        s2_sign = size_sign(r1_size);
        s2_a    = r1_a & s2_mask;
        s2_b    = r1_b & s2_mask;
        s2_x    = s2_a;
        s2_y    = s2_b;
        s2_c    = '0;
        s2_sub  = 1'b0;
        case (t_op'(r1_op))
            OP_SUB: begin
                s2_sub = 1'b1;
            end
            OP_ADC: begin
                s2_c = {63'd0, r1_cin};
            end
            OP_SBB: begin
                s2_sub = 1'b1;
                s2_c   = {63'd0, r1_cin};
            end
            OP_INC: begin
                s2_y = 64'd1;
            end
            OP_DEC: begin
                s2_sub = 1'b1;
                s2_y   = 64'd1;
            end
            OP_NEG: begin
                s2_sub = 1'b1;
                s2_x   = '0;
                s2_y   = s2_a;
            end
            default: begin
            end
        endcase

        if (s2_sub) begin
            s2_r  = (s2_x - s2_y - s2_c) & s2_mask;
            n2_cf = |(((~s2_x & s2_y) | ((~s2_x | s2_y) & s2_r)) & s2_sign);
            n2_of = |(((s2_x ^ s2_y) & (s2_x ^ s2_r)) & s2_sign);
        end else begin
            s2_r  = (s2_x + s2_y + s2_c) & s2_mask;
            n2_cf = |(((s2_x & s2_y) | ((s2_x | s2_y) & ~s2_r)) & s2_sign);
            n2_of = |(((s2_x ^ s2_r) & (s2_y ^ s2_r)) & s2_sign);
        end

        n2_res    = '0;
        n2_second = '0;
        n2_flags  = '0;
        n2_fmask  = FLAGS_NONE;
        case (t_op'(r1_op))
            OP_ADD, OP_SUB, OP_ADC, OP_SBB, OP_NEG, OP_XADD: begin
                n2_res   = s2_r;
                n2_flags = '{of: n2_of, sf: |(s2_r & s2_sign), zf: (s2_r == '0),
                             af: s2_x[4] ^ s2_y[4] ^ s2_r[4], pf: ~^s2_r[7:0],
                             cf: n2_cf};
                n2_fmask = FLAGS_ALL;
                if (t_op'(r1_op) == OP_XADD) begin
                    n2_second = s2_a;
                end
            end
            OP_INC, OP_DEC: begin
                n2_res   = s2_r;
                n2_flags = '{of: n2_of, sf: |(s2_r & s2_sign), zf: (s2_r == '0),
                             af: s2_x[4] ^ s2_y[4] ^ s2_r[4], pf: ~^s2_r[7:0],
                             cf: r1_cin};
                n2_fmask = FLAGS_NO_CF;
            end
            default: begin
            end
        endcase
    end

    // stage 3 logic
    t_word s3_mid, s3_lo, s3_hi, s3_high;

    always_comb begin
        s3_mid = {32'd0, r2_ll[63:32]} + {32'd0, r2_lh[31:0]} + {32'd0, r2_hl[31:0]};
        s3_lo  = {s3_mid[31:0], r2_ll[31:0]};
        s3_hi  = r2_hh + {32'd0, r2_lh[63:32]} + {32'd0, r2_hl[63:32]}
                 + {32'd0, s3_mid[63:32]};
        case (r2_size)
            SIZE_8:  s3_high = {56'd0, s3_lo[15:8]};
            SIZE_16: s3_high = {48'd0, s3_lo[31:16]};
            SIZE_32: s3_high = {32'd0, s3_lo[63:32]};
            default: s3_high = s3_hi;
        endcase
    end

    // stage 4 logic
    t_word s4_mask, s4_sign, s4_lo, s4_corr_a, s4_corr_b, s4_high_s, s4_ext;
    logic  s4_cf;

    always_comb begin
        s4_mask   = size_mask(r3_size);
        s4_sign   = size_sign(r3_size);
        s4_lo     = r3_lo & s4_mask;
        s4_corr_a = |(r3_a & s4_sign) ? r3_b : '0;
        s4_corr_b = |(r3_b & s4_sign) ? r3_a : '0;
        s4_high_s = (r3_high - s4_corr_a - s4_corr_b) & s4_mask;
        s4_ext    = |(s4_lo & s4_sign) ? s4_mask : '0;
        s4_cf     = r3_is_imul ? (s4_high_s != s4_ext) : (r3_high != '0);

        if (r3_is_mul) begin
            n4_res    = s4_lo;
            n4_second = r3_is_imul ? s4_high_s : r3_high;
            n4_flags  = '{of: s4_cf, sf: 1'b0, zf: 1'b0, af: 1'b0, pf: 1'b0, cf: s4_cf};
            n4_fmask  = FLAGS_CF_OF;
        end else begin
            n4_res    = r3_res;
            n4_second = r3_second;
            n4_flags  = r3_flags;
            n4_fmask  = r3_fmask;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (en1) r1_valid <= i_valid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
            if (en4) r4_valid <= r3_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_op   <= i_op;
            r1_size <= t_size'(i_size_code);
            r1_a    <= i_operand_a;
            r1_b    <= i_operand_b;
            r1_cin  <= i_carry_in;
        end
        if (en2) begin
            r2_is_mul  <= (t_op'(r1_op) == OP_MUL) || (t_op'(r1_op) == OP_IMUL);
            r2_is_imul <= (t_op'(r1_op) == OP_IMUL);
            r2_size    <= r1_size;
            r2_a       <= s2_a;
            r2_b       <= s2_b;
            r2_ll      <= s2_a[31:0]  * s2_b[31:0];
            r2_lh      <= s2_a[31:0]  * s2_b[63:32];
            r2_hl      <= s2_a[63:32] * s2_b[31:0];
            r2_hh      <= s2_a[63:32] * s2_b[63:32];
            r2_res     <= n2_res;
            r2_second  <= n2_second;
            r2_flags   <= n2_flags;
            r2_fmask   <= n2_fmask;
        end
        if (en3) begin
            r3_is_mul  <= r2_is_mul;
            r3_is_imul <= r2_is_imul;
            r3_size    <= r2_size;
            r3_a       <= r2_a;
            r3_b       <= r2_b;
            r3_lo      <= s3_lo;
            r3_high    <= s3_high;
            r3_res     <= r2_res;
            r3_second  <= r2_second;
            r3_flags   <= r2_flags;
            r3_fmask   <= r2_fmask;
        end
        if (en4) begin
            r4_res    <= n4_res;
            r4_second <= n4_second;
            r4_flags  <= n4_flags;
            r4_fmask  <= n4_fmask;
        end
    end

    assign o_valid           = r4_valid;
    assign o_result          = r4_res;
    assign o_second_value    = r4_second;
    assign o_carry_flag      = r4_flags.cf;
    assign o_parity_flag     = r4_flags.pf;
    assign o_adjust_flag     = r4_flags.af;
    assign o_zero_flag       = r4_flags.zf;
    assign o_sign_flag       = r4_flags.sf;
    assign o_overflow_flag   = r4_flags.of;
    assign o_flag_write_mask = r4_fmask;

endmodule

@@ tb/x86_integer_alu_with_flags_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// x86_integer_alu_with_flags_core_test
// Self-checking bench for the pipelined x86 integer ALU. A directed set hits
// the flag corner cases of the add/sub family, inc/dec/neg, xadd, the two
// multiplies and the unused op codes. A long random run with bursty input
// and patterned output stall follows. Every result is compared field by field
// against an in-bench model of the x86 arithmetic and flag rules.
// ----------------------------------------------------------------------------
module x86_integer_alu_with_flags_core_test;
    import xalu_pkg::*;

    localparam int unsigned OP_CODE_MAX  = 15;
    localparam int unsigned RANDOM_ITEMS = 1750;
    localparam int unsigned PRINT_LIMIT  = 40;

    typedef struct packed {
        t_word  res;
        t_word  second;
        t_flags flags;
        t_fmask wmask;
    } alu_outcome_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [3:0]  i_op;
    logic [1:0]  i_size_code;
    logic [63:0] i_operand_a;
    logic [63:0] i_operand_b;
    logic        i_carry_in;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_result;
    logic [63:0] o_second_value;
    logic        o_carry_flag;
    logic        o_parity_flag;
    logic        o_adjust_flag;
    logic        o_zero_flag;
    logic        o_sign_flag;
    logic        o_overflow_flag;
    logic [5:0]  o_flag_write_mask;

    alu_outcome_t pending_q[$];
    int unsigned  error_count;
    int unsigned  sent_count;
    int unsigned  checked_count;
    int unsigned  op_seen[OP_CODE_MAX+1];
    int unsigned  burst_left;
    int unsigned  stall_left;
    int unsigned  stall_mode;
    int unsigned  stall_tick;

    x86_integer_alu_with_flags_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_op              (i_op),
        .i_size_code       (i_size_code),
        .i_operand_a       (i_operand_a),
        .i_operand_b       (i_operand_b),
        .i_carry_in        (i_carry_in),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_result          (o_result),
        .o_second_value    (o_second_value),
        .o_carry_flag      (o_carry_flag),
        .o_parity_flag     (o_parity_flag),
        .o_adjust_flag     (o_adjust_flag),
        .o_zero_flag       (o_zero_flag),
        .o_sign_flag       (o_sign_flag),
        .o_overflow_flag   (o_overflow_flag),
        .o_flag_write_mask (o_flag_write_mask)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic alu_outcome_t predict_alu(logic [3:0] op, t_size sz, t_word a_raw,
                                                 t_word b_raw, logic cin);
        alu_outcome_t o;
        int unsigned  w;
        t_word        m;
        t_word        s;
        t_word        a;
        t_word        b;
        t_word        x;
        t_word        y;
        t_word        c;
        t_word        r;
        t_word        high;
        t_word        sa;
        t_word        sb;
        logic [127:0] prod;
        logic         is_sub;
        o = '0;
        w = 8 << sz;
        m = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
        s = 64'd1 << (w - 1);
        a = a_raw & m;
        b = b_raw & m;
        if (op <= OP_XADD) begin
            is_sub = (op == OP_SUB) || (op == OP_SBB) || (op == OP_DEC) || (op == OP_NEG);
            x = a;
            y = b;
            c = '0;
            if (op == OP_ADC || op == OP_SBB) c = {63'd0, cin};
            if (op == OP_INC || op == OP_DEC) y = 64'd1;
            if (op == OP_NEG) begin
                x = '0;
                y = a;
            end
            if (is_sub) begin
                r = (x - y - c) & m;
                o.flags.cf = |((((~x) & y) | (((~x) | y) & r)) & s);
                o.flags.of = |(((x ^ y) & (x ^ r)) & s);
            end else begin
                r = (x + y + c) & m;
                o.flags.cf = |(((x & y) | ((x | y) & ~r)) & s);
                o.flags.of = |(((x ^ r) & (y ^ r)) & s);
            end
            o.res      = r;
            o.flags.af = |((x ^ y ^ r) & 64'h10);
            o.flags.pf = ~^r[7:0];
            o.flags.zf = (r == '0);
            o.flags.sf = |(r & s);
            o.wmask    = FLAGS_ALL;
            if (op == OP_INC || op == OP_DEC) begin
                o.flags.cf = cin;
                o.wmask    = FLAGS_NO_CF;
            end
            if (op == OP_XADD) o.second = a;
        end else if (op == OP_MUL || op == OP_IMUL) begin
            if (op == OP_IMUL) begin
                sa   = |(a & s) ? (a | ~m) : a;
                sb   = |(b & s) ? (b | ~m) : b;
                prod = {{64{sa[63]}}, sa} * {{64{sb[63]}}, sb};
            end else begin
                prod = {64'd0, a} * {64'd0, b};
            end
            r    = prod[63:0] & m;
            high = t_word'(prod >> w) & m;
            if (op == OP_IMUL) o.flags.cf = (high != (|(r & s) ? m : '0));
            else o.flags.cf = (high != '0);
            o.flags.of = o.flags.cf;
            o.res      = r;
            o.second   = high;
            o.wmask    = FLAGS_CF_OF;
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, t_word got, t_word want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    // sender pacing: bursts of random length with random gaps between them
    task automatic send_item(logic [3:0] op, t_size sz, t_word a, t_word b, logic cin);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_op        <= op;
        i_size_code <= sz;
        i_operand_a <= a;
        i_operand_b <= b;
        i_carry_in  <= cin;
        do @(posedge i_clk); while (o_stall);
        pending_q.push_back(predict_alu(op, sz, a, b, cin));
        sent_count++;
        op_seen[op]++;
    endtask

    function automatic t_word pick_operand();
        t_word v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2:       v = 64'd1 << $urandom_range(0, 63);
            3:       v = ~(64'd1 << $urandom_range(0, 63));
            4:       v = 64'($urandom_range(0, 20));
            5:       v = (64'd1 << (8 << $urandom_range(0, 3)) - 1) - 64'($urandom_range(0, 2));
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // output side stall: runs of no stall, random stall and two regular patterns
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 80);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 2) == 0);
            2:       i_stall <= (stall_tick % 5 != 0);
            default: i_stall <= (stall_tick % 4 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        alu_outcome_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected transfer", o_result, '0);
            end else begin
                want = pending_q.pop_front();
                checked_count++;
                if (o_result !== want.res) report_mismatch("result", o_result, want.res);
                if (o_second_value !== want.second)
                    report_mismatch("second_value", o_second_value, want.second);
                if (o_carry_flag !== want.flags.cf)
                    report_mismatch("carry_flag", t_word'(o_carry_flag),
                                    t_word'(want.flags.cf));
                if (o_parity_flag !== want.flags.pf)
                    report_mismatch("parity_flag", t_word'(o_parity_flag),
                                    t_word'(want.flags.pf));
                if (o_adjust_flag !== want.flags.af)
                    report_mismatch("adjust_flag", t_word'(o_adjust_flag),
                                    t_word'(want.flags.af));
                if (o_zero_flag !== want.flags.zf)
                    report_mismatch("zero_flag", t_word'(o_zero_flag),
                                    t_word'(want.flags.zf));
                if (o_sign_flag !== want.flags.sf)
                    report_mismatch("sign_flag", t_word'(o_sign_flag),
                                    t_word'(want.flags.sf));
                if (o_overflow_flag !== want.flags.of)
                    report_mismatch("overflow_flag", t_word'(o_overflow_flag),
                                    t_word'(want.flags.of));
                if (o_flag_write_mask !== want.wmask)
                    report_mismatch("flag_write_mask", t_word'(o_flag_write_mask),
                                    t_word'(want.wmask));
            end
        end
    end

    task automatic test_add_sub_family();
        send_item(OP_ADD, SIZE_8, 64'h7F, 64'h01, 1'b0);
        send_item(OP_ADD, SIZE_64, '1, 64'h1, 1'b1);
        send_item(OP_ADC, SIZE_16, 64'hFFFF, 64'h0, 1'b1);
        send_item(OP_SUB, SIZE_32, 64'h0, 64'h1, 1'b0);
        send_item(OP_SUB, SIZE_8, 64'h80, 64'h01, 1'b1);
        // zero result that still overflows
        send_item(OP_SBB, SIZE_64, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_item(OP_SBB, SIZE_8, 64'hFFFF_FFFF_FFFF_FF00, 64'hFF, 1'b1);
    endtask

    task automatic test_inc_dec_neg();
        send_item(OP_INC, SIZE_8, 64'h7F, '1, 1'b1);
        send_item(OP_DEC, SIZE_16, 64'h8000, 64'h0, 1'b0);
        send_item(OP_INC, SIZE_64, '1, 64'h0, 1'b0);
        send_item(OP_NEG, SIZE_32, 64'h8000_0000, '1, 1'b0);
        send_item(OP_NEG, SIZE_8, 64'hFF00, 64'h5, 1'b1);
    endtask

    task automatic test_xadd();
        send_item(OP_XADD, SIZE_8, '1, '1, 1'b1);
        send_item(OP_XADD, SIZE_64, 64'h7FFF_FFFF_FFFF_FFFF, 64'h1, 1'b0);
    endtask

    task automatic test_multiply();
        send_item(OP_MUL, SIZE_64, '1, '1, 1'b0);
        send_item(OP_MUL, SIZE_8, 64'h10, 64'h10, 1'b1);
        send_item(OP_MUL, SIZE_16, 64'h0, 64'hABCD, 1'b0);
        send_item(OP_IMUL, SIZE_8, 64'h80, 64'hFF, 1'b0);
        send_item(OP_IMUL, SIZE_64, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1);
        send_item(OP_IMUL, SIZE_32, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_unused_ops();
        send_item(4'(OP_IMUL + 1), SIZE_32, '1, '1, 1'b1);
        send_item(4'(OP_CODE_MAX), SIZE_64, '1, '1, 1'b1);
    endtask

    task automatic test_random_mix();
        logic [3:0] op;
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 15) == 0) op = 4'($urandom_range(OP_IMUL + 1, OP_CODE_MAX));
            else op = 4'($urandom_range(OP_ADD, OP_IMUL));
            send_item(op, t_size'($urandom_range(SIZE_8, SIZE_64)), pick_operand(),
                      pick_operand(), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_op        <= OP_ADD;
        i_size_code <= SIZE_8;
        i_operand_a <= '0;
        i_operand_b <= '0;
        i_carry_in  <= 1'b0;
        error_count   = 0;
        sent_count    = 0;
        checked_count = 0;
        burst_left    = 0;
        foreach (op_seen[k]) op_seen[k] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_add_sub_family();
        test_inc_dec_neg();
        test_xadd();
        test_multiply();
        test_unused_ops();
        test_random_mix();
        i_valid <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (pending_q.size() != 0)
            report_mismatch("results left over", t_word'(pending_q.size()), '0);

        $display("run covered %0d transfers over all ops, unused codes and four sizes",
                 sent_count);
        $display("%0d results checked, %0d mul, %0d imul, %0d mismatches", checked_count,
                 op_seen[OP_MUL], op_seen[OP_IMUL], error_count);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
